// ===== sv/letterbox_bilinear_resize_assert.svh =====
// assertion macros for the letterbox resize block
`ifndef LETTERBOX_BILINEAR_RESIZE_ASSERT_SVH
`define LETTERBOX_BILINEAR_RESIZE_ASSERT_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define LBR_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lbr check failed");
// antecedent implies consequent in the next cycle
`define LBR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lbr check failed");
`else
`define LBR_ASSERT_IMPLIES(lbl, ante, cons)
`define LBR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== sv/lbr_pkg.sv =====
// shared types, constants and sizes of the letterbox resize block
package lbr_pkg;

  localparam int MAX_SRC_WIDTH  = 1024;
  localparam int MAX_SRC_HEIGHT = 1024;
  localparam int TARGET_SIZE    = 640;

  localparam int SIZE_W  = 11;
  localparam int COORD_W = 10;
  localparam int PAD_W   = 9;
  localparam int FRAC_W  = 16;
  localparam int CH_W    = 8;
  localparam int OUT_W   = 16;
  localparam int NUM_CH  = 3;

  // banked store: two row parities by two column parities
  localparam int NUM_BANKS = 4;
  localparam int ROW_W     = $clog2(MAX_SRC_HEIGHT) - 1;
  localparam int COL_W     = $clog2(MAX_SRC_WIDTH) - 1;
  localparam int BANK_AW   = ROW_W + COL_W;
  localparam int BANK_DEPTH = 2 ** BANK_AW;

  // opcodes
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  // register indexes
  localparam logic CFG_SRC_WIDTH  = 1'b0;
  localparam logic CFG_SRC_HEIGHT = 1'b1;

  // pad channel value, 114/255 in Q1.15 rounded
  localparam logic [OUT_W-1:0] PAD_LEVEL = OUT_W'((114 * 32768 + 127) / 255);
  localparam logic [OUT_W-1:0] FULL_SCALE = OUT_W'(32768);

  typedef logic [NUM_CH-1:0][CH_W-1:0] pixel_t;

  typedef struct packed {
    logic               opcode;
    logic [COORD_W-1:0] loc_x;
    logic [COORD_W-1:0] loc_y;
    logic [CH_W-1:0]    red_in;
    logic [CH_W-1:0]    green_in;
    logic [CH_W-1:0]    blue_in;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] out_x;
    logic [COORD_W-1:0] out_y;
    logic [OUT_W-1:0]   out_red;
    logic [OUT_W-1:0]   out_green;
    logic [OUT_W-1:0]   out_blue;
    logic               is_padding;
  } out_item_t;

  // frame geometry derived from the size registers
  typedef struct packed {
    logic [SIZE_W-1:0]  w;
    logic [SIZE_W-1:0]  h;
    logic [SIZE_W-1:0]  m;
    logic [COORD_W-1:0] nw;
    logic [COORD_W-1:0] nh;
    logic [PAD_W-1:0]   px;
    logic [PAD_W-1:0]   py;
  } geom_t;

  // mapped source neighborhood of one destination pixel
  typedef struct packed {
    logic               valid;
    logic               pad;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] y0;
    logic [COORD_W-1:0] y1;
    logic [FRAC_W-1:0]  fx;
    logic [FRAC_W-1:0]  fy;
  } map_t;

endpackage

// ===== sv/lbr_geom.sv =====
// size registers and serial divider for the scaled frame geometry
module lbr_geom (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic                       cfg_idx,
  input  logic [lbr_pkg::SIZE_W-1:0] cfg_wdata,
  output lbr_pkg::geom_t             geom,
  output logic                       busy
);
  import lbr_pkg::*;

  localparam int NUM_W = $clog2(MAX_SRC_WIDTH * TARGET_SIZE + 1);
  localparam int QUO_W = COORD_W;

  typedef enum logic [1:0] {
    GEO_IDLE = 2'b01,
    GEO_DIV  = 2'b10
  } geo_state_t;

  geo_state_t         state_r;
  logic [SIZE_W-1:0]  src_width_r, src_height_r;
  logic               restart_r;
  logic [SIZE_W-1:0]  w_c, h_c, m_c, min_c;
  logic [NUM_W-1:0]   num_c;
  logic [SIZE_W-1:0]  w_r, h_r, m_r, rem_r;
  logic               wide_r;
  logic [QUO_W-1:0]   num_r, quo_r;
  logic [3:0]         cnt_r;
  logic [SIZE_W:0]    trial;
  logic               ge;
  logic [SIZE_W-1:0]  rem_nxt;
  logic [QUO_W-1:0]   quo_nxt;
  logic [COORD_W-1:0] nw_fin, nh_fin;
  geom_t              geom_r;

  // clamp the sizes and set up the divide
  always_comb begin
    w_c = src_width_r;
    if (src_width_r == '0) w_c = SIZE_W'(1);
    else if (src_width_r > SIZE_W'(MAX_SRC_WIDTH)) w_c = SIZE_W'(MAX_SRC_WIDTH);
    h_c = src_height_r;
    if (src_height_r == '0) h_c = SIZE_W'(1);
    else if (src_height_r > SIZE_W'(MAX_SRC_HEIGHT)) h_c = SIZE_W'(MAX_SRC_HEIGHT);
    m_c   = (w_c >= h_c) ? w_c : h_c;
    min_c = (w_c >= h_c) ? h_c : w_c;
    num_c = NUM_W'(min_c) * NUM_W'(TARGET_SIZE);
  end

  // one restoring divide step
  always_comb begin
    trial   = {rem_r, num_r[QUO_W-1]};
    ge      = trial >= {1'b0, m_r};
    rem_nxt = ge ? SIZE_W'(trial - {1'b0, m_r}) : SIZE_W'(trial);
    quo_nxt = {quo_r[QUO_W-2:0], ge};
    nw_fin  = wide_r ? COORD_W'(TARGET_SIZE) : quo_nxt;
    nh_fin  = wide_r ? quo_nxt : COORD_W'(TARGET_SIZE);
  end

  // register writes and divide sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= GEO_IDLE;
      restart_r    <= 1'b0;
      src_width_r  <= SIZE_W'(TARGET_SIZE);
      src_height_r <= SIZE_W'(TARGET_SIZE);
      cnt_r        <= '0;
      geom_r.w     <= SIZE_W'(TARGET_SIZE);
      geom_r.h     <= SIZE_W'(TARGET_SIZE);
      geom_r.m     <= SIZE_W'(TARGET_SIZE);
      geom_r.nw    <= COORD_W'(TARGET_SIZE);
      geom_r.nh    <= COORD_W'(TARGET_SIZE);
      geom_r.px    <= '0;
      geom_r.py    <= '0;
    end else begin
      restart_r <= cfg_we;
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_SRC_WIDTH:  src_width_r  <= cfg_wdata;
          CFG_SRC_HEIGHT: src_height_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (restart_r) begin
        state_r <= GEO_DIV;
        cnt_r   <= '0;
        w_r     <= w_c;
        h_r     <= h_c;
        m_r     <= m_c;
        wide_r  <= w_c >= h_c;
        rem_r   <= SIZE_W'(num_c[NUM_W-1:QUO_W]);
        num_r   <= num_c[QUO_W-1:0];
        quo_r   <= '0;
      end else begin
        unique case (state_r)
          GEO_IDLE: ;
          GEO_DIV: begin
            rem_r <= rem_nxt;
            quo_r <= quo_nxt;
            num_r <= {num_r[QUO_W-2:0], 1'b0};
            cnt_r <= cnt_r + 4'd1;
            if (cnt_r == 4'(QUO_W - 1)) begin
              state_r   <= GEO_IDLE;
              geom_r.w  <= w_r;
              geom_r.h  <= h_r;
              geom_r.m  <= m_r;
              geom_r.nw <= nw_fin;
              geom_r.nh <= nh_fin;
              geom_r.px <= PAD_W'((COORD_W'(TARGET_SIZE) - nw_fin) >> 1);
              geom_r.py <= PAD_W'((COORD_W'(TARGET_SIZE) - nh_fin) >> 1);
            end
          end
          default: state_r <= GEO_IDLE;
        endcase
      end
    end
  end

  assign geom = geom_r;
  assign busy = restart_r || (state_r == GEO_DIV);

endmodule

// ===== sv/lbr_map.sv =====
// padding test and source coordinate mapping, four stages
module lbr_map (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_v,
  input  logic [lbr_pkg::COORD_W-1:0] in_x,
  input  logic [lbr_pkg::COORD_W-1:0] in_y,
  input  lbr_pkg::geom_t              geom,
  output lbr_pkg::map_t               map_out
);
  import lbr_pkg::*;

  localparam int A_W = 2 * SIZE_W;
  localparam int N_W = A_W - 1;
  localparam int Q_W = 28;
  localparam int L_W = COORD_W + FRAC_W;
  // q = (n << 16) / (2 * TARGET_SIZE) = 51n + n/5, with n/5 by reciprocal
  localparam int DIV_MUL      = 51;
  localparam int RECIP5       = 1677722;
  localparam int RECIP5_SHIFT = 23;

  typedef struct packed {
    logic [COORD_W-1:0] i0;
    logic [COORD_W-1:0] i1;
    logic [FRAC_W-1:0]  f;
  } axis_t;

  function automatic logic [Q_W-1:0] src_q(input logic [A_W-1:0] a);
    logic [N_W-1:0]   n;
    logic [2*N_W-1:0] p;
    n = (a > A_W'(TARGET_SIZE)) ? N_W'(a - A_W'(TARGET_SIZE)) : '0;
    p = (2*N_W)'(n) * (2*N_W)'(RECIP5);
    return Q_W'(n) * Q_W'(DIV_MUL) + Q_W'(p >> RECIP5_SHIFT);
  endfunction

  function automatic axis_t clamp_axis(input logic [Q_W-1:0] q,
                                       input logic [SIZE_W-1:0] size);
    logic [L_W-1:0] lim, qc;
    axis_t          r;
    lim  = {COORD_W'(size - SIZE_W'(1)), FRAC_W'(0)};
    qc   = (q > Q_W'(lim)) ? lim : q[L_W-1:0];
    r.i0 = qc[L_W-1:FRAC_W];
    r.f  = qc[FRAC_W-1:0];
    r.i1 = (SIZE_W'(r.i0) + SIZE_W'(1) < size) ? COORD_W'(r.i0 + COORD_W'(1))
                                               : COORD_W'(size - SIZE_W'(1));
    return r;
  endfunction

  logic               v1_r, v2_r, v3_r;
  logic               pad2_r, pad3_r;
  logic [COORD_W-1:0] x1_r, y1_r, x2_r, y2_r, x3_r, y3_r;
  logic [A_W-1:0]     ax2_r, ay2_r;
  logic [Q_W-1:0]     qx3_r, qy3_r;
  logic               pad1;
  logic [COORD_W-1:0] dx, dy;
  axis_t              ax_c, ay_c;
  map_t               map_r;

  // stage 1: padding test and centre offset times max size
  always_comb begin
    pad1 = (SIZE_W'(x1_r) < SIZE_W'(geom.px)) ||
           (SIZE_W'(x1_r) >= SIZE_W'(geom.px) + SIZE_W'(geom.nw)) ||
           (SIZE_W'(y1_r) < SIZE_W'(geom.py)) ||
           (SIZE_W'(y1_r) >= SIZE_W'(geom.py) + SIZE_W'(geom.nh));
    dx = x1_r - COORD_W'(geom.px);
    dy = y1_r - COORD_W'(geom.py);
  end

  // stage 3: clamp and split into index pair and weight
  always_comb begin
    ax_c = clamp_axis(qx3_r, geom.w);
    ay_c = clamp_axis(qy3_r, geom.h);
  end

  // valid bits and payload stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      map_r.valid <= 1'b0;
    end else begin
      v1_r <= in_v && (in_x < COORD_W'(TARGET_SIZE)) && (in_y < COORD_W'(TARGET_SIZE));
      v2_r <= v1_r;
      v3_r <= v2_r;
      map_r.valid <= v3_r;
    end
    x1_r   <= in_x;
    y1_r   <= in_y;
    pad2_r <= pad1;
    x2_r   <= x1_r;
    y2_r   <= y1_r;
    ax2_r  <= A_W'({dx, 1'b1}) * A_W'(geom.m);
    ay2_r  <= A_W'({dy, 1'b1}) * A_W'(geom.m);
    pad3_r <= pad2_r;
    x3_r   <= x2_r;
    y3_r   <= y2_r;
    qx3_r  <= src_q(ax2_r);
    qy3_r  <= src_q(ay2_r);
    map_r.pad <= pad3_r;
    map_r.x   <= x3_r;
    map_r.y   <= y3_r;
    map_r.x0  <= ax_c.i0;
    map_r.x1  <= ax_c.i1;
    map_r.fx  <= ax_c.f;
    map_r.y0  <= ay_c.i0;
    map_r.y1  <= ay_c.i1;
    map_r.fy  <= ay_c.f;
  end

  assign map_out = map_r;

endmodule

// ===== sv/lbr_frame_store.sv =====
// source frame store in four parity banks, one neighbor read per bank
module lbr_frame_store (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      wr_en,
  input  logic [lbr_pkg::COORD_W-1:0]               wr_x,
  input  logic [lbr_pkg::COORD_W-1:0]               wr_y,
  input  lbr_pkg::pixel_t                           wr_pix,
  input  lbr_pkg::map_t                             rd_map,
  output lbr_pkg::pixel_t [lbr_pkg::NUM_BANKS-1:0]  rd_pix
);
  import lbr_pkg::*;

  // load writes trail the accept by as many stages as compute reads do
  localparam int WR_DELAY = 4;

  pixel_t                           bank_mem [NUM_BANKS][BANK_DEPTH];
  pixel_t [NUM_BANKS-1:0]           rd_pix_r;
  logic [$clog2(NUM_BANKS)-1:0]     wr_bank;
  logic [WR_DELAY-1:0]              wv_r;
  logic [WR_DELAY-1:0][COORD_W-1:0] wx_r, wy_r;
  pixel_t [WR_DELAY-1:0]            wp_r;

  // delay line for load transfers, keeps loads and reads in transfer order
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wv_r <= '0;
    end else begin
      wv_r <= {wv_r[WR_DELAY-2:0], wr_en};
    end
    wx_r <= {wx_r[WR_DELAY-2:0], wr_x};
    wy_r <= {wy_r[WR_DELAY-2:0], wr_y};
    wp_r <= {wp_r[WR_DELAY-2:0], wr_pix};
  end

  assign wr_bank = {wy_r[WR_DELAY-1][0], wx_r[WR_DELAY-1][0]};

  // load transfer write
  always_ff @(posedge clk) begin
    if (wv_r[WR_DELAY-1]) begin
      bank_mem[wr_bank][{wy_r[WR_DELAY-1][COORD_W-1:1], wx_r[WR_DELAY-1][COORD_W-1:1]}]
        <= wp_r[WR_DELAY-1];
    end
  end

  // each bank reads whichever neighbor row and column has its parity
  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    always_comb begin
      row = (rd_map.y0[0] == 1'(b >> 1)) ? rd_map.y0[COORD_W-1:1] : rd_map.y1[COORD_W-1:1];
      col = (rd_map.x0[0] == 1'(b))      ? rd_map.x0[COORD_W-1:1] : rd_map.x1[COORD_W-1:1];
    end
    always_ff @(posedge clk) begin
      rd_pix_r[b] <= bank_mem[b][{row, col}];
    end
  end

  assign rd_pix = rd_pix_r;

endmodule

// ===== sv/lbr_blend.sv =====
// bilinear blend and divide by 255, three stages plus output register
module lbr_blend (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  lbr_pkg::map_t                            map_in,
  input  lbr_pkg::pixel_t [lbr_pkg::NUM_BANKS-1:0] rd_pix,
  output logic                                     out_strobe,
  output lbr_pkg::out_item_t                       out_data
);
  import lbr_pkg::*;

  localparam int H_W   = CH_W + FRAC_W;
  localparam int ACC_W = H_W + FRAC_W + 2;
  localparam int T_W   = H_W;
  // floor(t / 255) as (t * ceil(2^32 / 255)) >> 32
  localparam int RECIP255       = 16843010;
  localparam int RECIP255_SHIFT = 32;
  localparam int RECIP_W        = 25;
  localparam int P_W            = T_W + RECIP_W;

  typedef struct packed {
    logic               valid;
    logic               pad;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [FRAC_W-1:0]  fy;
  } meta_t;

  map_t                            m4_r;
  meta_t                           m5_r, m6_r;
  logic [NUM_CH-1:0][H_W-1:0]      top_r, bot_r, top_c, bot_c;
  logic [NUM_CH-1:0][T_W-1:0]      t_r, t_c;
  logic [NUM_CH-1:0][OUT_W-1:0]    q_c;
  pixel_t                          p00, p01, p10, p11;
  logic signed [CH_W:0]            dtop, dbot;
  logic signed [H_W+1:0]           htop, hbot;
  logic signed [H_W:0]             vdiff;
  logic signed [ACC_W-1:0]         vprod, acc;
  logic [ACC_W-1:0]                rnd;
  logic [P_W-1:0]                  prod;
  logic                            strobe_r;
  out_item_t                       out_r;

  // stage 4: pick neighbors from banks and blend across columns
  always_comb begin
    p00 = rd_pix[{m4_r.y0[0], m4_r.x0[0]}];
    p01 = rd_pix[{m4_r.y0[0], m4_r.x1[0]}];
    p10 = rd_pix[{m4_r.y1[0], m4_r.x0[0]}];
    p11 = rd_pix[{m4_r.y1[0], m4_r.x1[0]}];
    for (int c = 0; c < NUM_CH; c++) begin
      dtop = $signed({1'b0, p01[c]}) - $signed({1'b0, p00[c]});
      dbot = $signed({1'b0, p11[c]}) - $signed({1'b0, p10[c]});
      htop = $signed({2'b0, p00[c], FRAC_W'(0)})
           + (H_W+2)'(dtop) * $signed((H_W+2)'({1'b0, m4_r.fx}));
      hbot = $signed({2'b0, p10[c], FRAC_W'(0)})
           + (H_W+2)'(dbot) * $signed((H_W+2)'({1'b0, m4_r.fx}));
      top_c[c] = htop[H_W-1:0];
      bot_c[c] = hbot[H_W-1:0];
    end
  end

  // stage 5: blend across rows, round and drop 17 bits
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      vdiff = $signed({1'b0, bot_r[c]}) - $signed({1'b0, top_r[c]});
      vprod = ACC_W'(vdiff) * $signed(ACC_W'({1'b0, m5_r.fy}));
      acc   = $signed({2'b0, top_r[c], FRAC_W'(0)}) + vprod;
      rnd   = ACC_W'(acc) + ACC_W'(255 << FRAC_W);
      t_c[c] = rnd[FRAC_W+T_W:FRAC_W+1];
    end
  end

  // stage 6: divide by 255
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      prod   = P_W'(t_r[c]) * P_W'(RECIP255);
      q_c[c] = OUT_W'(prod >> RECIP255_SHIFT);
    end
  end

  // valid bits and payload stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m4_r.valid <= 1'b0;
      m5_r.valid <= 1'b0;
      m6_r.valid <= 1'b0;
      strobe_r   <= 1'b0;
    end else begin
      m4_r.valid <= map_in.valid;
      m5_r.valid <= m4_r.valid;
      m6_r.valid <= m5_r.valid;
      strobe_r   <= m6_r.valid;
    end
    m4_r.pad <= map_in.pad;
    m4_r.x   <= map_in.x;
    m4_r.y   <= map_in.y;
    m4_r.x0  <= map_in.x0;
    m4_r.x1  <= map_in.x1;
    m4_r.y0  <= map_in.y0;
    m4_r.y1  <= map_in.y1;
    m4_r.fx  <= map_in.fx;
    m4_r.fy  <= map_in.fy;
    m5_r.pad <= m4_r.pad;
    m5_r.x   <= m4_r.x;
    m5_r.y   <= m4_r.y;
    m5_r.fy  <= m4_r.fy;
    top_r    <= top_c;
    bot_r    <= bot_c;
    m6_r.pad <= m5_r.pad;
    m6_r.x   <= m5_r.x;
    m6_r.y   <= m5_r.y;
    m6_r.fy  <= m5_r.fy;
    t_r      <= t_c;
    out_r.out_x      <= m6_r.x;
    out_r.out_y      <= m6_r.y;
    out_r.is_padding <= m6_r.pad;
    out_r.out_red    <= m6_r.pad ? PAD_LEVEL : q_c[2];
    out_r.out_green  <= m6_r.pad ? PAD_LEVEL : q_c[1];
    out_r.out_blue   <= m6_r.pad ? PAD_LEVEL : q_c[0];
  end

  assign out_strobe = strobe_r;
  assign out_data   = out_r;

endmodule

// ===== sv/letterbox_bilinear_resize.sv =====
// top level of the letterbox bilinear resize block
`include "letterbox_bilinear_resize_assert.svh"

// Takes one item per clock while busy is low: a load item writes one source
// pixel, a compute item returns its 640x640 destination pixel on out_data
// with out_strobe high for one cycle, after the eight register stages of
// the map and blend pipeline (the bank read sits in one of them). Loads
// reach the store in step with the compute reads, so a compute sees exactly
// the loads accepted before it. The store has four parity banks so all four
// neighbors are read in the same cycle. Results cannot be held off. After
// any size register write, busy is high while the serial divider works out
// the scaled size and padding; compute items that fall outside 640x640 give
// no result, load items never do.
module letterbox_bilinear_resize (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  lbr_pkg::in_item_t          in_data,
  output logic                       out_strobe,
  output lbr_pkg::out_item_t         out_data,
  input  logic                       cfg_we,
  input  logic                       cfg_idx,
  input  logic [lbr_pkg::SIZE_W-1:0] cfg_wdata
);
  import lbr_pkg::*;

  geom_t                   geom;
  map_t                    map_w;
  pixel_t [NUM_BANKS-1:0]  rd_pix;
  pixel_t                  wr_pix;
  logic                    accept;

  assign accept = start && !busy;
  assign wr_pix = {in_data.red_in, in_data.green_in, in_data.blue_in};

  lbr_geom u_geom (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .geom      (geom),
    .busy      (busy)
  );

  lbr_map u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_v    (accept && (in_data.opcode == OP_COMPUTE)),
    .in_x    (in_data.loc_x),
    .in_y    (in_data.loc_y),
    .geom    (geom),
    .map_out (map_w)
  );

  lbr_frame_store u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (accept && (in_data.opcode == OP_LOAD)),
    .wr_x   (in_data.loc_x),
    .wr_y   (in_data.loc_y),
    .wr_pix (wr_pix),
    .rd_map (map_w),
    .rd_pix (rd_pix)
  );

  lbr_blend u_blend (
    .clk        (clk),
    .rst_n      (rst_n),
    .map_in     (map_w),
    .rd_pix     (rd_pix),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

  // geometry after a divide always has one side at full target size
  `LBR_ASSERT_IMPLIES(a_geom_full_side, $fell(busy), (geom.nw == 10'(TARGET_SIZE)) || (geom.nh == 10'(TARGET_SIZE)))
  // results only for destination pixels inside the target
  `LBR_ASSERT_IMPLIES(a_out_in_range, out_strobe, (out_data.out_x < 10'(TARGET_SIZE)) && (out_data.out_y < 10'(TARGET_SIZE)))
  // padding pixels carry the pad value on the red and blue channels
  `LBR_ASSERT_IMPLIES(a_pad_value, out_strobe && out_data.is_padding, (out_data.out_red == PAD_LEVEL) && (out_data.out_blue == PAD_LEVEL))
  // red and green blended channels never exceed full scale
  `LBR_ASSERT_IMPLIES(a_full_scale, out_strobe, (out_data.out_red <= FULL_SCALE) && (out_data.out_green <= FULL_SCALE))
  // a config write always raises busy on the next cycle
  `LBR_ASSERT_NEXT(a_cfg_busy, cfg_we, busy)

endmodule
